@@ hdl/cartesian_polar_converter_assert.svh @@
// Assertion macros used by the converter's top level.
`ifndef CARTESIAN_POLAR_CONVERTER_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CPC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/cpc_pkg.sv @@
// Types and constants of the cartesian/polar converter.
package cpc_pkg;

   localparam int ITERATIONS_DEFAULT = 16;
   localparam int DATA_WIDTH_DEFAULT = 16;

   localparam int FIRST_W   = 17;
   localparam int SECOND_W  = 16;
   localparam int ANGLE_W   = 32;
   localparam int ATAN_DEPTH = 24;

   // integer bits of the datapath above the guard bits
   localparam int INT_W     = 19;
   // descale: low slice of each product operand, gain width, rounded result width
   localparam int LO_W      = 16;
   localparam int KINV_W    = 20;
   localparam int RES_W     = 20;

   localparam logic [KINV_W-1:0]  KINV     = 20'd636751;
   localparam logic [ANGLE_W-1:0] ANGLE_PI = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0] PHASE_RND = 32'h0000_8000;

   localparam logic signed [RES_W-1:0] MAG_MAX = 20'sd65535;
   localparam logic signed [RES_W-1:0] REC_MAX = 20'sd32767;
   localparam logic signed [RES_W-1:0] REC_MIN = -20'sd32768;

   // arctan(2^-i) in turns, pi = 2^31
   localparam logic [ANGLE_W-1:0] ATAN_ANGLE [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic {
      OP_TO_POLAR = 1'b0,
      OP_TO_RECT  = 1'b1
   } op_type;

   typedef struct packed {
      op_type op;
      logic   zero;
   } tag_type;

endpackage

@@ hdl/cpc_cell.sv @@
// One CORDIC micro-rotation stage with its own pipeline register.
module cpc_cell #(
   parameter int STAGE = 0,
   parameter int XW    = 27
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  cpc_pkg::tag_type                in_tag,
   input  logic signed [XW-1:0]            in_x,
   input  logic signed [XW-1:0]            in_y,
   input  logic [cpc_pkg::ANGLE_W-1:0]     in_z,
   output logic                            up_stall,
   output logic                            out_valid,
   output cpc_pkg::tag_type                out_tag,
   output logic signed [XW-1:0]            out_x,
   output logic signed [XW-1:0]            out_y,
   output logic [cpc_pkg::ANGLE_W-1:0]     out_z,
   input  logic                            down_stall
);

   logic                        valid_ff;
   cpc_pkg::tag_type            tag_ff;
   logic signed [XW-1:0]        x_ff, x_in;
   logic signed [XW-1:0]        y_ff, y_in;
   logic [cpc_pkg::ANGLE_W-1:0] z_ff, z_in;
   logic signed [XW-1:0]        x_sh, y_sh;
   logic                        turn_neg;

   assign x_sh = in_x >>> STAGE;
   assign y_sh = in_y >>> STAGE;

   // rotation steers by the residual angle, vectoring by the sign of y
   assign turn_neg = (in_tag.op == cpc_pkg::OP_TO_RECT) ? ~in_z[cpc_pkg::ANGLE_W-1]
                                                         : in_y[XW-1];

   always_comb begin
      if (turn_neg) begin
         x_in = in_x - y_sh;
         y_in = in_y + x_sh;
         z_in = in_z - cpc_pkg::ATAN_ANGLE[STAGE];
      end else begin
         x_in = in_x + y_sh;
         y_in = in_y - x_sh;
         z_in = in_z + cpc_pkg::ATAN_ANGLE[STAGE];
      end
   end

   assign up_stall = valid_ff & down_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && in_valid) begin
         tag_ff <= in_tag;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

@@ hdl/cpc_scale.sv @@
// Gain removal, rounding and saturation: a multiply stage and the result register.
module cpc_scale #(
   parameter int GUARD = 8,
   parameter int XW    = 27
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  cpc_pkg::tag_type                    in_tag,
   input  logic signed [XW-1:0]                in_x,
   input  logic signed [XW-1:0]                in_y,
   input  logic [cpc_pkg::ANGLE_W-1:0]         in_z,
   output logic                                up_stall,
   output logic                                out_valid,
   output logic signed [cpc_pkg::FIRST_W-1:0]  out_first,
   output logic signed [cpc_pkg::SECOND_W-1:0] out_second,
   input  logic                                down_stall
);

   localparam int HW  = XW - cpc_pkg::LO_W;
   localparam int HPW = HW + cpc_pkg::KINV_W + 1;
   localparam int LPW = cpc_pkg::LO_W + cpc_pkg::KINV_W;
   localparam int SW  = XW + cpc_pkg::KINV_W + 2;
   localparam int SHR = cpc_pkg::KINV_W + GUARD;

   localparam logic signed [cpc_pkg::KINV_W:0] KINV_S = {1'b0, cpc_pkg::KINV};
   localparam logic signed [SW-1:0]            RND    = SW'(1) <<< (SHR - 1);

   function automatic logic signed [cpc_pkg::RES_W-1:0] sat(
      input logic signed [cpc_pkg::RES_W-1:0] v,
      input logic signed [cpc_pkg::RES_W-1:0] lo,
      input logic signed [cpc_pkg::RES_W-1:0] hi
   );
      logic signed [cpc_pkg::RES_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // multiply stage
   logic                                mul_valid_ff;
   logic                                mul_stall;
   cpc_pkg::tag_type                    mul_tag_ff;
   logic signed [HPW-1:0]               hp_x_ff, hp_x_in, hp_y_ff, hp_y_in;
   logic [LPW-1:0]                      lp_x_ff, lp_x_in, lp_y_ff, lp_y_in;
   logic [cpc_pkg::SECOND_W-1:0]        phase_ff;
   logic [cpc_pkg::ANGLE_W-1:0]         z_rnd;

   // result stage
   logic                                res_valid_ff;
   logic signed [cpc_pkg::FIRST_W-1:0]  first_ff, first_in;
   logic signed [cpc_pkg::SECOND_W-1:0] second_ff, second_in;
   logic signed [SW-1:0]                sum_x, sum_y;
   logic signed [cpc_pkg::RES_W-1:0]    r_x, r_y, mag, rec_x, rec_y;

   // split each operand so no product is wider than 36 bits
   assign hp_x_in = HPW'(signed'(in_x[XW-1 -: HW])) * HPW'(KINV_S);
   assign hp_y_in = HPW'(signed'(in_y[XW-1 -: HW])) * HPW'(KINV_S);
   assign lp_x_in = LPW'(in_x[cpc_pkg::LO_W-1:0]) * LPW'(cpc_pkg::KINV);
   assign lp_y_in = LPW'(in_y[cpc_pkg::LO_W-1:0]) * LPW'(cpc_pkg::KINV);
   assign z_rnd   = in_z + cpc_pkg::PHASE_RND;

   assign out_valid = res_valid_ff;
   assign mul_stall = mul_valid_ff & res_valid_ff & down_stall;
   assign up_stall  = mul_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (!mul_stall) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!mul_stall && in_valid) begin
         mul_tag_ff <= in_tag;
         hp_x_ff    <= hp_x_in;
         hp_y_ff    <= hp_y_in;
         lp_x_ff    <= lp_x_in;
         lp_y_ff    <= lp_y_in;
         phase_ff   <= z_rnd[cpc_pkg::ANGLE_W-1 -: cpc_pkg::SECOND_W];
      end
   end

   assign sum_x = (SW'(hp_x_ff) <<< cpc_pkg::LO_W) + SW'(signed'({1'b0, lp_x_ff})) + RND;
   assign sum_y = (SW'(hp_y_ff) <<< cpc_pkg::LO_W) + SW'(signed'({1'b0, lp_y_ff})) + RND;
   assign r_x   = sum_x[SHR +: cpc_pkg::RES_W];
   assign r_y   = sum_y[SHR +: cpc_pkg::RES_W];
   assign mag   = sat(r_x, '0, cpc_pkg::MAG_MAX);
   assign rec_x = sat(r_x, cpc_pkg::REC_MIN, cpc_pkg::REC_MAX);
   assign rec_y = sat(r_y, cpc_pkg::REC_MIN, cpc_pkg::REC_MAX);

   always_comb begin
      case (mul_tag_ff.op)
         cpc_pkg::OP_TO_POLAR: begin
            if (mul_tag_ff.zero) begin
               first_in  = '0;
               second_in = '0;
            end else begin
               first_in  = mag[cpc_pkg::FIRST_W-1:0];
               second_in = phase_ff;
            end
         end
         cpc_pkg::OP_TO_RECT: begin
            first_in  = rec_x[cpc_pkg::FIRST_W-1:0];
            second_in = rec_y[cpc_pkg::SECOND_W-1:0];
         end
         default: begin
            first_in  = '0;
            second_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (!(res_valid_ff && down_stall)) begin
         res_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!(res_valid_ff && down_stall) && mul_valid_ff) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign out_first  = first_ff;
   assign out_second = second_ff;

endmodule

@@ hdl/cartesian_polar_converter.sv @@
// Cartesian/polar converter top level: input setup, CORDIC cell chain, descale.
//
// Converts one bin per cycle, when not stalled, between (re, im) and (magnitude,
// phase) with a fully pipelined CORDIC. Every micro-rotation is a cell of its
// own with a register, so a new word is taken each cycle unless req_stall is
// high. The stages are one setup stage (quadrant fold), ITERATIONS cells,
// one stage of gain multipliers, and the result register. Each stage holds
// its word only while the next one is full and stalled, so bubbles are
// squeezed out and req_stall rises only when the whole chain is full and
// rsp_stall is high. Phase is in units of pi/32768; rectangular results
// saturate to 16 bits and the magnitude to 65535.
`include "cartesian_polar_converter_assert.svh"

module cartesian_polar_converter #(
   parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEFAULT,
   parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic signed [cpc_pkg::FIRST_W-1:0]  req_first_value,
   input  logic signed [cpc_pkg::SECOND_W-1:0] req_second_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cpc_pkg::FIRST_W-1:0]  rsp_first_result,
   output logic signed [cpc_pkg::SECOND_W-1:0] rsp_second_result
);

   localparam int GUARD = DATA_WIDTH - 8;
   localparam int XW    = GUARD + cpc_pkg::INT_W;

   logic                        valid_pipe [ITERATIONS+1];
   logic                        stall_pipe [ITERATIONS+1];
   cpc_pkg::tag_type            tag_pipe   [ITERATIONS+1];
   logic signed [XW-1:0]        x_pipe     [ITERATIONS+1];
   logic signed [XW-1:0]        y_pipe     [ITERATIONS+1];
   logic [cpc_pkg::ANGLE_W-1:0] z_pipe     [ITERATIONS+1];

   // setup stage
   logic                        prep_valid_ff;
   cpc_pkg::tag_type            prep_tag_ff, prep_tag_in;
   logic signed [XW-1:0]        prep_x_ff, prep_x_in;
   logic signed [XW-1:0]        prep_y_ff, prep_y_in;
   logic [cpc_pkg::ANGLE_W-1:0] prep_z_ff, prep_z_in;
   logic signed [XW-1:0]        a_ext, b_ext;
   logic [cpc_pkg::ANGLE_W-1:0] phase_in;

   assign a_ext    = XW'(req_first_value) <<< GUARD;
   assign b_ext    = XW'(req_second_value) <<< GUARD;
   assign phase_in = {req_second_value, {(cpc_pkg::ANGLE_W-cpc_pkg::SECOND_W){1'b0}}};

   always_comb begin
      prep_tag_in.op   = cpc_pkg::op_type'(req_operation);
      prep_tag_in.zero = 1'b0;
      case (prep_tag_in.op)
         cpc_pkg::OP_TO_POLAR: begin
            prep_tag_in.zero = (req_first_value == '0) && (req_second_value == '0);
            // fold the left half-plane over, starting from pi
            if (req_first_value < 0) begin
               prep_x_in = -a_ext;
               prep_y_in = -b_ext;
               prep_z_in = cpc_pkg::ANGLE_PI;
            end else begin
               prep_x_in = a_ext;
               prep_y_in = b_ext;
               prep_z_in = '0;
            end
         end
         cpc_pkg::OP_TO_RECT: begin
            prep_y_in = '0;
            // bring the angle into -pi/2..pi/2 by negating the magnitude
            if (phase_in[cpc_pkg::ANGLE_W-1] ^ phase_in[cpc_pkg::ANGLE_W-2]) begin
               prep_x_in = -a_ext;
               prep_z_in = phase_in ^ cpc_pkg::ANGLE_PI;
            end else begin
               prep_x_in = a_ext;
               prep_z_in = phase_in;
            end
         end
         default: begin
            prep_x_in = a_ext;
            prep_y_in = b_ext;
            prep_z_in = '0;
         end
      endcase
   end

   assign req_stall = prep_valid_ff & stall_pipe[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         prep_tag_ff <= prep_tag_in;
         prep_x_ff   <= prep_x_in;
         prep_y_ff   <= prep_y_in;
         prep_z_ff   <= prep_z_in;
      end
   end

   assign valid_pipe[0] = prep_valid_ff;
   assign tag_pipe[0]   = prep_tag_ff;
   assign x_pipe[0]     = prep_x_ff;
   assign y_pipe[0]     = prep_y_ff;
   assign z_pipe[0]     = prep_z_ff;

   for (genvar j = 0; j < ITERATIONS; j++) begin : g_cell
      cpc_cell #(
         .STAGE (j),
         .XW    (XW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (valid_pipe[j]),
         .in_tag     (tag_pipe[j]),
         .in_x       (x_pipe[j]),
         .in_y       (y_pipe[j]),
         .in_z       (z_pipe[j]),
         .up_stall   (stall_pipe[j]),
         .out_valid  (valid_pipe[j+1]),
         .out_tag    (tag_pipe[j+1]),
         .out_x      (x_pipe[j+1]),
         .out_y      (y_pipe[j+1]),
         .out_z      (z_pipe[j+1]),
         .down_stall (stall_pipe[j+1])
      );
   end

   cpc_scale #(
      .GUARD (GUARD),
      .XW    (XW)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_pipe[ITERATIONS]),
      .in_tag     (tag_pipe[ITERATIONS]),
      .in_x       (x_pipe[ITERATIONS]),
      .in_y       (y_pipe[ITERATIONS]),
      .in_z       (z_pipe[ITERATIONS]),
      .up_stall   (stall_pipe[ITERATIONS]),
      .out_valid  (rsp_valid),
      .out_first  (rsp_first_result),
      .out_second (rsp_second_result),
      .down_stall (rsp_stall)
   );

   `CPC_ASSERT_IMPL(a_stall_only_when_full, req_stall,
                    rsp_valid && valid_pipe[ITERATIONS], "input stalled with room in the chain")
   `CPC_ASSERT_IMPL(a_polar_x_folded,
                    valid_pipe[0] && (tag_pipe[0].op == cpc_pkg::OP_TO_POLAR),
                    !x_pipe[0][XW-1], "vectoring setup left x negative")
   `CPC_ASSERT_IMPL(a_rect_angle_folded,
                    valid_pipe[0] && (tag_pipe[0].op == cpc_pkg::OP_TO_RECT),
                    z_pipe[0][cpc_pkg::ANGLE_W-1] == z_pipe[0][cpc_pkg::ANGLE_W-2],
                    "rotation setup left angle outside half circle")
   `CPC_ASSERT_NEXT(a_setup_holds, valid_pipe[0] && stall_pipe[0],
                    valid_pipe[0] && $stable(z_pipe[0]) && $stable(x_pipe[0]),
                    "setup stage changed while stalled")

endmodule

@@ dv/tb_cartesian_polar_converter.sv @@
// Self-checking testbench for the cartesian/polar CORDIC converter.
module tb_cartesian_polar_converter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CORDIC_STEPS = 16;
   localparam int  FRAC_BITS    = 8;          // DATA_WIDTH 16 less 8
   localparam longint GAIN_INV  = 636751;     // 1/K in Q20
   localparam int  RANDOM_BINS  = 1950;
   localparam int  HOLD_CYCLES  = 64;
   localparam int  DRAIN_CYCLES = 40;

   // arctan(2^-i) with pi = 2^31
   localparam bit [31:0] ARCTAN_TURNS [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      cpc_pkg::op_type                      op;
      logic signed [cpc_pkg::FIRST_W-1:0]   first;
      logic signed [cpc_pkg::SECOND_W-1:0]  second;
   } bin_word_type;

   typedef struct packed {
      logic signed [cpc_pkg::FIRST_W-1:0]   first;
      logic signed [cpc_pkg::SECOND_W-1:0]  second;
   } bin_result_type;

   localparam bin_word_type DIRECTED [23] = '{
      '{cpc_pkg::OP_TO_POLAR,  17'sd0,      16'sd0},
      '{cpc_pkg::OP_TO_POLAR,  17'sd65535,  16'sd32767},
      '{cpc_pkg::OP_TO_POLAR, -17'sd65536, -16'sd32768},
      '{cpc_pkg::OP_TO_POLAR, -17'sd65536,  16'sd0},
      '{cpc_pkg::OP_TO_POLAR, -17'sd100,    16'sd0},
      '{cpc_pkg::OP_TO_POLAR, -17'sd65536, -16'sd1},
      '{cpc_pkg::OP_TO_POLAR, -17'sd65536,  16'sd32767},
      '{cpc_pkg::OP_TO_POLAR,  17'sd1,      16'sd0},
      '{cpc_pkg::OP_TO_POLAR,  17'sd0,      16'sd32767},
      '{cpc_pkg::OP_TO_POLAR,  17'sd0,     -16'sd32768},
      '{cpc_pkg::OP_TO_POLAR,  17'sd65535,  16'sd0},
      '{cpc_pkg::OP_TO_POLAR, -17'sd1,     -16'sd1},
      '{cpc_pkg::OP_TO_RECT,   17'sd46341,  16'sd8192},
      '{cpc_pkg::OP_TO_RECT,   17'sd65535,  16'sd0},
      '{cpc_pkg::OP_TO_RECT,  -17'sd65536,  16'sd0},
      '{cpc_pkg::OP_TO_RECT,  -17'sd46341, -16'sd32768},
      '{cpc_pkg::OP_TO_RECT,   17'sd1000,   16'sd32767},
      '{cpc_pkg::OP_TO_RECT,   17'sd1000,  -16'sd32768},
      '{cpc_pkg::OP_TO_RECT,   17'sd0,      16'sd12345},
      '{cpc_pkg::OP_TO_RECT,   17'sd46341,  16'sd16384},
      '{cpc_pkg::OP_TO_RECT,   17'sd46341, -16'sd16384},
      '{cpc_pkg::OP_TO_RECT,  -17'sd12345,  16'sd5000},
      '{cpc_pkg::OP_TO_RECT,   17'sd12345, -16'sd24576}
   };

   class bin_scoreboard_type;
      bin_result_type expected_bins[$];
      int mismatches;
      int bins_checked;
      int polar_bins;
      int rect_bins;

      static function longint remove_gain(longint v);
         return (v * GAIN_INV + (longint'(1) <<< (19 + FRAC_BITS))) >>> (20 + FRAC_BITS);
      endfunction

      static function longint saturate(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      static function bin_result_type convert_bin(bin_word_type w);
         longint         x, y, t;
         bit [31:0]      z;
         bit [31:0]      z_round;
         bin_result_type r;
         x = longint'(w.first) * (longint'(1) <<< FRAC_BITS);
         if (w.op == cpc_pkg::OP_TO_POLAR) begin
            if (w.first == 0 && w.second == 0) begin
               r.first  = '0;
               r.second = '0;
               return r;
            end
            y = longint'(w.second) * (longint'(1) <<< FRAC_BITS);
            z = '0;
            // fold the left half plane onto the right
            if (x < 0) begin
               x = -x;
               y = -y;
               z = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
               t = x;
               if (y < 0) begin
                  x = x - (y >>> i);
                  y = y + (t >>> i);
                  z = z - ARCTAN_TURNS[i];
               end else begin
                  x = x + (y >>> i);
                  y = y - (t >>> i);
                  z = z + ARCTAN_TURNS[i];
               end
            end
            r.first  = cpc_pkg::FIRST_W'(saturate(remove_gain(x), 0, 65535));
            z_round  = z + 32'h0000_8000;
            r.second = z_round[31:16];
         end else begin
            y = 0;
            z = {w.second, 16'h0000};
            // bring the angle into -pi/2..pi/2 by flipping the vector
            if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
               x = -x;
               z = z ^ 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
               t = x;
               if (z[31]) begin
                  x = x + (y >>> i);
                  y = y - (t >>> i);
                  z = z + ARCTAN_TURNS[i];
               end else begin
                  x = x - (y >>> i);
                  y = y + (t >>> i);
                  z = z - ARCTAN_TURNS[i];
               end
            end
            r.first  = cpc_pkg::FIRST_W'(saturate(remove_gain(x), -32768, 32767));
            r.second = cpc_pkg::SECOND_W'(saturate(remove_gain(y), -32768, 32767));
         end
         return r;
      endfunction

      function void note_bin(bin_word_type w);
         expected_bins.push_back(convert_bin(w));
         if (w.op == cpc_pkg::OP_TO_POLAR) polar_bins++;
         else rect_bins++;
      endfunction

      function void check_bin(logic signed [cpc_pkg::FIRST_W-1:0] first,
                              logic signed [cpc_pkg::SECOND_W-1:0] second);
         bin_result_type want;
         if (expected_bins.size() == 0) begin
            mismatches++;
            $display("%0t: result %0d/%0d with nothing expected", $realtime, first, second);
            return;
         end
         want = expected_bins.pop_front();
         bins_checked++;
         if (first !== want.first) begin
            mismatches++;
            $display("%0t: first_result expected %0d actual %0d",
                     $realtime, want.first, first);
         end
         if (second !== want.second) begin
            mismatches++;
            $display("%0t: second_result expected %0d actual %0d",
                     $realtime, want.second, second);
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_operation;
   logic signed [cpc_pkg::FIRST_W-1:0]   req_first_value;
   logic signed [cpc_pkg::SECOND_W-1:0]  req_second_value;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic signed [cpc_pkg::FIRST_W-1:0]   rsp_first_result;
   logic signed [cpc_pkg::SECOND_W-1:0]  rsp_second_result;

   bin_scoreboard_type sb = new();
   bit quiet_stretch;
   bit hold_pending;
   int holds_done;

   cartesian_polar_converter #(
      .ITERATIONS (CORDIC_STEPS),
      .DATA_WIDTH (16)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_first_value   (req_first_value),
      .req_second_value  (req_second_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_result  (rsp_first_result),
      .rsp_second_result (rsp_second_result)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one word, with random idle cycles first; return once it is taken.
   task automatic send_bin(bin_word_type w);
      @(negedge clock);
      while (!quiet_stretch && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= w.op;
      req_first_value  <= w.first;
      req_second_value <= w.second;
      do @(posedge clock); while (req_stall);
      sb.note_bin(w);
   endtask

   function automatic bin_word_type random_bin();
      bin_word_type w;
      int           pick;
      w.op   = cpc_pkg::op_type'($urandom_range(1));
      pick   = $urandom_range(99);
      w.second = cpc_pkg::SECOND_W'($urandom());
      if (pick < 10) begin
         // near the origin
         w.first  = cpc_pkg::FIRST_W'(int'($urandom_range(16)) - 8);
         w.second = cpc_pkg::SECOND_W'(int'($urandom_range(16)) - 8);
      end else if (w.op == cpc_pkg::OP_TO_RECT && pick < 80) begin
         w.first = cpc_pkg::FIRST_W'($urandom_range(46341));
      end else begin
         w.first = cpc_pkg::FIRST_W'($urandom());
      end
      return w;
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end else begin
            rsp_stall <= !quiet_stretch && ($urandom_range(99) < 11);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_bin(rsp_first_result, rsp_second_result);
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = cpc_pkg::OP_TO_POLAR;
      req_first_value  = '0;
      req_second_value = '0;
      quiet_stretch    = 1'b0;
      hold_pending     = 1'b0;
      holds_done       = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[k]) send_bin(DIRECTED[k]);
      for (int n = 0; n < RANDOM_BINS; n++) begin
         quiet_stretch = (n >= 800 && n < 1100);
         if (n == 300 || n == 1400) hold_pending = 1'b1;
         send_bin(random_bin());
      end
      quiet_stretch = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.expected_bins.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d bins to polar and %0d to rectangular, %0d results compared,",
               sb.polar_bins, sb.rect_bins, sb.bins_checked);
      $display("with %0d long receiver hold-offs and %0d field mismatches.",
               holds_done, sb.mismatches);
      if (sb.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #4800000;
      $display("Timeout with %0d results outstanding", sb.expected_bins.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cpc_pkg.sv
hdl/cpc_cell.sv
hdl/cpc_scale.sv
hdl/cartesian_polar_converter.sv
dv/tb_cartesian_polar_converter.sv
